// ===== src/mpd_pkg.sv =====
// Shared constants and types for the magnet pass detector.
// No dependencies; every other file takes names from here by scope.
package mpd_pkg;

	localparam int ANGLE_WIDTH     = 16;
	localparam int COUNT_WIDTH     = 16;
	localparam int CFG_DATA_WIDTH  = 16;
	localparam int CFG_INDEX_WIDTH = 8;
	localparam int NUM_MAGNETS     = 3;

	// Register indexes of the configuration port
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAGNET_POS_A  = CFG_INDEX_WIDTH'(0);
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAGNET_POS_B  = CFG_INDEX_WIDTH'(1);
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAGNET_POS_C  = CFG_INDEX_WIDTH'(2);
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_DETECT_WINDOW = CFG_INDEX_WIDTH'(3);

	// Reset values
	localparam logic [CFG_DATA_WIDTH-1:0] RST_MAGNET_POS_A  = CFG_DATA_WIDTH'(0);
	localparam logic [CFG_DATA_WIDTH-1:0] RST_MAGNET_POS_B  = CFG_DATA_WIDTH'(21845);
	localparam logic [CFG_DATA_WIDTH-1:0] RST_MAGNET_POS_C  = CFG_DATA_WIDTH'(43691);
	localparam logic [CFG_DATA_WIDTH-1:0] RST_DETECT_WINDOW = CFG_DATA_WIDTH'(910);

	localparam logic [ANGLE_WIDTH-1:0] HALF_TURN = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 1);

	typedef struct packed {
		logic [NUM_MAGNETS-1:0][ANGLE_WIDTH-1:0] mag;
		logic [CFG_DATA_WIDTH-1:0]               window;
	} cfg_t;

endpackage

// ===== src/magnet_pass_detector_top.sv =====
// Magnet pass detector, top level: input stage, three magnet checks, result stage.
// Depends on mpd_pkg, mpd_cfg_regs and mpd_magnet_check.
//
// One item per clock is sustained while the output is not stalled: an angle pair is
// taken into the input register, the three magnet checks run side by side
// combinationally on it, and the hits and updated pass counters land in the result
// register, which drives out_valid. A stalled output holds the result register, then
// the input register, then the input. The hit flags and pass counters are the result
// register itself; reset clears them to zero. Configuration writes are always ready
// and take effect at once; write them only while no item is in flight.
module magnet_pass_detector_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mpd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [mpd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [mpd_pkg::ANGLE_WIDTH-1:0]     from_angle,
	input  logic [mpd_pkg::ANGLE_WIDTH-1:0]     to_angle,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                sensor_level,
	output logic                                hit_a,
	output logic                                hit_b,
	output logic                                hit_c,
	output logic [mpd_pkg::COUNT_WIDTH-1:0]     passes_a,
	output logic [mpd_pkg::COUNT_WIDTH-1:0]     passes_b,
	output logic [mpd_pkg::COUNT_WIDTH-1:0]     passes_c
);

	localparam int NM = mpd_pkg::NUM_MAGNETS;

	mpd_pkg::cfg_t cfg;

	logic                                      valid_s1;
	logic [mpd_pkg::ANGLE_WIDTH-1:0]           from_s1;
	logic [mpd_pkg::ANGLE_WIDTH-1:0]           to_s1;
	logic                                      valid_s2;
	logic [NM-1:0]                             hit;
	logic [NM-1:0]                             prev_hit_q;
	logic [NM-1:0][mpd_pkg::COUNT_WIDTH-1:0]   pass_count_q;
	logic                                      adv_s2;

	assign cfg_ready = 1'b1;

	mpd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	for (genvar k = 0; k < NM; k++) begin : g_mag
		mpd_magnet_check u_check (
			.mag        (cfg.mag[k]),
			.from_angle (from_s1),
			.to_angle   (to_s1),
			.window     (cfg.window),
			.hit        (hit[k])
		);
	end

	// advance stage 1 into the result stage when that stage is free or draining
	assign adv_s2   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			from_s1 <= from_angle;
			to_s1   <= to_angle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2     <= 1'b0;
			prev_hit_q   <= '0;
			pass_count_q <= '0;
		end else begin
			if (adv_s2) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
			if (adv_s2) begin
				prev_hit_q <= hit;
				for (int k = 0; k < NM; k++) begin
					// count rising edges of each hit
					if (hit[k] && !prev_hit_q[k]) begin
						pass_count_q[k] <= pass_count_q[k] + mpd_pkg::COUNT_WIDTH'(1);
					end
				end
			end
		end
	end

	assign out_valid    = valid_s2;
	assign sensor_level = ~|prev_hit_q;
	assign hit_a        = prev_hit_q[0];
	assign hit_b        = prev_hit_q[1];
	assign hit_c        = prev_hit_q[2];
	assign passes_a     = pass_count_q[0];
	assign passes_b     = pass_count_q[1];
	assign passes_c     = pass_count_q[2];

endmodule

// ===== src/mpd_cfg_regs.sv =====
// Configuration register file: magnet positions and detection window.
// Depends on mpd_pkg.
module mpd_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [mpd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [mpd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
	output mpd_pkg::cfg_t                       cfg
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.mag[0] <= mpd_pkg::ANGLE_WIDTH'(mpd_pkg::RST_MAGNET_POS_A);
			cfg.mag[1] <= mpd_pkg::ANGLE_WIDTH'(mpd_pkg::RST_MAGNET_POS_B);
			cfg.mag[2] <= mpd_pkg::ANGLE_WIDTH'(mpd_pkg::RST_MAGNET_POS_C);
			cfg.window <= mpd_pkg::RST_DETECT_WINDOW;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				mpd_pkg::REG_MAGNET_POS_A:  cfg.mag[0] <= cfg_data[mpd_pkg::ANGLE_WIDTH-1:0];
				mpd_pkg::REG_MAGNET_POS_B:  cfg.mag[1] <= cfg_data[mpd_pkg::ANGLE_WIDTH-1:0];
				mpd_pkg::REG_MAGNET_POS_C:  cfg.mag[2] <= cfg_data[mpd_pkg::ANGLE_WIDTH-1:0];
				mpd_pkg::REG_DETECT_WINDOW: cfg.window <= cfg_data;
				default: begin
					// unknown index: drop the write
				end
			endcase
		end
	end

endmodule

// ===== src/mpd_magnet_check.sv =====
// Per-magnet hit logic: circular window test plus strict crossing test.
// Depends on mpd_pkg.
module mpd_magnet_check (
	input  logic [mpd_pkg::ANGLE_WIDTH-1:0]    mag,
	input  logic [mpd_pkg::ANGLE_WIDTH-1:0]    from_angle,
	input  logic [mpd_pkg::ANGLE_WIDTH-1:0]    to_angle,
	input  logic [mpd_pkg::CFG_DATA_WIDTH-1:0] window,
	output logic                               hit
);

	localparam int AW = mpd_pkg::ANGLE_WIDTH;
	localparam int CW = (AW > mpd_pkg::CFG_DATA_WIDTH) ? AW : mpd_pkg::CFG_DATA_WIDTH;

	logic [AW-1:0] ofs;
	logic [AW-1:0] gap;
	logic [AW-1:0] move;
	logic          move_half;
	logic          from_lt_to;
	logic          from_gt_to;
	logic          fwd;
	logic          bwd;
	logic          in_win;
	logic          crossed;

	always_comb begin
		// shortest circular distance from the magnet
		ofs    = to_angle - mag;
		gap    = (ofs > mpd_pkg::HALF_TURN) ? (~ofs + AW'(1)) : ofs;
		in_win = CW'(gap) <= CW'(window);

		// direction of motion after wrapping the delta into a half turn
		move       = to_angle - from_angle;
		move_half  = move == mpd_pkg::HALF_TURN;
		from_lt_to = from_angle < to_angle;
		from_gt_to = from_angle > to_angle;
		fwd = (move != '0) && (move_half ? from_lt_to : !move[AW-1]);
		bwd = move_half ? from_gt_to : move[AW-1];

		if (fwd) begin
			crossed = from_lt_to ? (mag > from_angle && mag < to_angle)
			                     : (mag > from_angle || mag < to_angle);
		end else if (bwd) begin
			crossed = from_gt_to ? (mag < from_angle && mag > to_angle)
			                     : (mag < from_angle || mag > to_angle);
		end else begin
			crossed = 1'b0;
		end

		hit = in_win || crossed;
	end

endmodule

// ===== src/mpd_checker.sv =====
// Port-level assertions for the magnet pass detector, bound to the top level.
// Depends on mpd_pkg and magnet_pass_detector_top.
module mpd_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                cfg_valid,
	input logic                                cfg_ready,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic                                sensor_level,
	input logic                                hit_a,
	input logic                                hit_b,
	input logic                                hit_c,
	input logic [mpd_pkg::COUNT_WIDTH-1:0]     passes_a,
	input logic [mpd_pkg::COUNT_WIDTH-1:0]     passes_b,
	input logic [mpd_pkg::COUNT_WIDTH-1:0]     passes_c
);

	localparam int CNT = mpd_pkg::COUNT_WIDTH;

	logic in_xfer;
	logic cfg_xfer;

	assign in_xfer  = in_valid && in_ready;
	assign cfg_xfer = cfg_valid && cfg_ready;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sensor_level) &&
			$stable(hit_a) && $stable(hit_b) && $stable(hit_c) &&
			$stable(passes_a) && $stable(passes_b) && $stable(passes_c))
		else $error("result changed while stalled");

	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sensor_level == !(hit_a || hit_b || hit_c))
		else $error("sensor level disagrees with hits");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && !out_valid |=> ##1 out_valid)
		else $error("accepted item did not reach the output");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && $past(out_valid) && !cfg_xfer |->
			(passes_a == $past(passes_a) || passes_a == CNT'($past(passes_a) + CNT'(1))))
		else $error("pass counter jumped");

endmodule

bind magnet_pass_detector_top mpd_checker u_mpd_checker (.*);
